/* rtl/htqp_pkg.sv */
// ----------------------------------------------------------------------------
// htqp_pkg
// types, constants and hash helpers shared by the hash table blocks
// ----------------------------------------------------------------------------
`default_nettype none

package htqp_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int KEY_BYTES  = 8;
   localparam int KEY_W      = 64;
   localparam int VALUE_BITS = 32;
   localparam int LIMIT_W    = 9;
   localparam int COUNT_W    = 9;
   localparam int BYTE_CNT_W = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [63:0] FNV_START = 64'hcbf29ce484222325;

   // commands
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNDEF  = 2'd3;

   // status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_NULL      = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key_bytes;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        value_out;
      logic [7:0]         slot_index;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic [1:0]            command;
      logic [KEY_W-1:0]      key;
      logic [VALUE_BITS-1:0] value;
      logic [IDX_W-1:0]      home;
   } item_type;

   // multiply by the fnv prime 2^40 + 0x1b3
   function automatic logic [63:0] fnv_mult(input logic [63:0] h);
      logic [63:0] lo;
      begin
         lo = h * 64'h1b3;
         fnv_mult = lo + {h[23:0], 40'd0};
      end
   endfunction

   // keep bytes up to the first zero byte
   function automatic logic [KEY_W-1:0] key_norm(input logic [63:0] raw);
      logic            live;
      logic [KEY_W-1:0] k;
      begin
         live = 1'b1;
         k    = '0;
         for (int b = 0; b < KEY_BYTES; b++) begin
            if (raw[b*8 +: 8] == 8'd0) begin
               live = 1'b0;
            end
            if (live) begin
               k[b*8 +: 8] = raw[b*8 +: 8];
            end
         end
         key_norm = k;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/hash_table_quadratic_probe.sv */
// each command is hashed, then walks the slot memory; no slot is probed for a null-value
//   insert, an undefined command or probe_limit 0, and at most probe_limit slots otherwise
// the hash of one command, one byte per cycle, overlaps the slot memory walk of an
//   earlier command through the queue
// reset: synchronous, active high; clears the occupied map, entry count and
//   queue and sets probe_limit to 256; key and value memories are not cleared
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe
// open-addressing key/value table with fnv-1a hashing and quadratic probing
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_quadratic_probe import htqp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // command transactions
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   // response transactions
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   // probe limit register write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LIMIT_W-1:0] csr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] entry_total;

   // front to queue
   logic     f_valid, f_ready;
   item_type f_item;
   // queue to back
   logic     b_valid, b_ready;
   item_type b_item;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // front: key trim and fnv-1a hash, one byte per cycle
   htqp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item_data  (f_item)
   );

   // decoupling queue so hashing overlaps probing
   htqp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_item),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_item)
   );

   // back: slot walk, memory updates and response register
   htqp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .probe_limit (limit_ff),
      .item_valid  (b_valid),
      .item_ready  (b_ready),
      .item_data   (b_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .entry_total (entry_total)
   );

`ifndef ASSERT_OFF
   // occupancy never exceeds the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      entry_total <= COUNT_W'(TABLE_SIZE))
      else $error("entry count above table size");

   // a found value is never null, since null inserts are rejected
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FOUND) |-> (rsp_data.value_out != '0))
      else $error("lookup found a null value");

   // only a lookup hit carries a value
   a_value_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_FOUND) |-> (rsp_data.value_out == '0))
      else $error("value returned without a hit");
`endif

endmodule

`default_nettype wire

/* rtl/htqp_front.sv */
// ----------------------------------------------------------------------------
// htqp_front
// accepts commands, trims the key and hashes it one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module htqp_front import htqp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          item_valid,
   input  wire logic     item_ready,
   output item_type      item_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            cmd_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [63:0]           hash_ff, hash_in;
   logic [BYTE_CNT_W-1:0] byte_ff, byte_in;
   logic [7:0]            cur_byte;

   assign req_ready = (state_ff == F_IDLE);

   always_comb begin
      cur_byte = 8'd0;
      if (byte_ff < BYTE_CNT_W'(KEY_BYTES)) begin
         cur_byte = key_ff[byte_ff[2:0]*8 +: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      byte_in  = byte_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_HASH;
               hash_in  = FNV_START;
               byte_in  = '0;
            end
         end
         F_HASH: begin
            hash_in = fnv_mult(hash_ff ^ {56'd0, cur_byte});
            byte_in = byte_ff + 1'b1;
            // the terminator byte is the last one hashed
            if (cur_byte == 8'd0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (item_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      byte_ff <= byte_in;
      if (req_valid && req_ready) begin
         cmd_ff <= req_data.command;
         key_ff <= key_norm(req_data.key_bytes);
         val_ff <= req_data.value[VALUE_BITS-1:0];
      end
   end

   assign item_valid        = (state_ff == F_PUSH);
   assign item_data.command = cmd_ff;
   assign item_data.key     = key_ff;
   assign item_data.value   = val_ff;
   assign item_data.home    = hash_ff[IDX_W-1:0];

endmodule

`default_nettype wire

/* rtl/htqp_fifo.sv */
// ----------------------------------------------------------------------------
// htqp_fifo
// two-entry queue between the hashing front and the probing back
// ----------------------------------------------------------------------------
`default_nettype none

module htqp_fifo import htqp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_valid,
   output logic          wr_ready,
   input  wire item_type wr_data,
   output logic          rd_valid,
   input  wire logic     rd_ready,
   output item_type      rd_data
);

   item_type    mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/htqp_back.sv */
// ----------------------------------------------------------------------------
// htqp_back
// probes the slot memories quadratically and registers the response
// ----------------------------------------------------------------------------
`default_nettype none

module htqp_back import htqp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [LIMIT_W-1:0] probe_limit,
   input  wire logic               item_valid,
   output logic                    item_ready,
   input  wire item_type           item_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   output logic [COUNT_W-1:0]      entry_total
);

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_READ  = 2'd1;
   localparam logic [1:0] B_CHECK = 2'd2;
   localparam logic [1:0] B_DONE  = 2'd3;

   logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
   logic [VALUE_BITS-1:0] val_mem [TABLE_SIZE];
   logic [KEY_W-1:0]      key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   logic [TABLE_SIZE-1:0] occ_ff, occ_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [1:0]            state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [LIMIT_W-1:0]    step_ff, step_in;
   logic [LIMIT_W-1:0]    n_ff, n_in;
   logic [2:0]            st_ff, st_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_key, wr_val;
   logic                  used, same;
   logic [2*IDX_W-1:0]    sq;

   assign used = occ_ff[idx_ff];
   assign same = used && (key_rd_ff == key_ff);
   assign sq   = step_ff[IDX_W-1:0] * step_ff[IDX_W-1:0];

   assign item_ready = (state_ff == B_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      st_in        = st_ff;
      vout_in      = vout_ff;
      slot_in      = slot_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      wr_key       = 1'b0;
      wr_val       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (item_valid) begin
               cmd_in  = item_data.command;
               key_in  = item_data.key;
               val_in  = item_data.value;
               idx_in  = item_data.home;
               step_in = (item_data.command == CMD_INSERT) ? LIMIT_W'(1) : '0;
               n_in    = '0;
               vout_in = '0;
               slot_in = '0;
               state_in = B_DONE;
               if (item_data.command == CMD_UNDEF) begin
                  st_in = ST_NOT_FOUND;
               end else if (item_data.command == CMD_INSERT &&
                            item_data.value == '0) begin
                  st_in = ST_NULL;
               end else if (probe_limit == '0) begin
                  st_in = ST_FULL;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            state_in = B_DONE;
            if (cmd_ff == CMD_INSERT && !used) begin
               occ_in[idx_ff] = 1'b1;
               wr_key  = 1'b1;
               wr_val  = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               st_in   = ST_INSERTED;
               slot_in = idx_ff;
            end else if (cmd_ff == CMD_INSERT && same) begin
               wr_val  = 1'b1;
               st_in   = ST_UPDATED;
               slot_in = idx_ff;
            end else if (cmd_ff != CMD_INSERT && !used) begin
               st_in = ST_NOT_FOUND;
            end else if (cmd_ff == CMD_LOOKUP && same) begin
               st_in   = ST_FOUND;
               vout_in = val_rd_ff;
               slot_in = idx_ff;
            end else if (cmd_ff == CMD_REMOVE && same) begin
               occ_in[idx_ff] = 1'b0;
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
               end
               st_in   = ST_REMOVED;
               slot_in = idx_ff;
            end else begin
               // advance along the quadratic chain
               idx_in  = idx_ff + sq[IDX_W-1:0];
               step_in = step_ff + 1'b1;
               n_in    = n_ff + 1'b1;
               if (n_ff + 1'b1 == probe_limit) begin
                  st_in = ST_FULL;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = st_ff;
               rsp_in.value_out    = vout_ff;
               rsp_in.slot_index   = slot_ff;
               rsp_in.entry_count  = cnt_ff;
               state_in            = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      n_ff    <= n_in;
      st_ff   <= st_in;
      vout_ff <= vout_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_key) begin
         key_mem[idx_ff] <= key_ff;
      end
      if (wr_val) begin
         val_mem[idx_ff] <= val_ff;
      end
      key_rd_ff <= key_mem[idx_ff];
      val_rd_ff <= val_mem[idx_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign entry_total = cnt_ff;

endmodule

`default_nettype wire

/* tb/hash_table_quadratic_probe_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe_test
// drives insert, lookup, remove and undefined commands into the quadratic-probe table,
// predicts every response with a behavioral table model and compares fields
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_quadratic_probe_test;
   import htqp_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [LIMIT_W-1:0] csr_data;

   hash_table_quadratic_probe DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predicted table contents
   logic [63:0]        tbl_key [TABLE_SIZE];
   logic [31:0]        tbl_val [TABLE_SIZE];
   logic               tbl_used [TABLE_SIZE];
   logic [COUNT_W-1:0] tbl_count;
   logic [LIMIT_W-1:0] cur_limit;

   rsp_type     pending_rsp[$];
   int          fail_count;
   int          rsp_seen;
   int          quiet_cycles;
   int          burst_left;
   int          gap_left;
   int          n_ins, n_upd, n_found, n_miss, n_rem, n_full, n_null;
   logic [63:0] key_pool [16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fnv-1a over the normalized key plus terminator, modulo table size
   function automatic logic [7:0] home_slot(input logic [63:0] raw, output logic [63:0] k);
      logic [63:0] h;
      logic        live;
      h    = 64'hcbf29ce484222325;
      k    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (raw[b*8 +: 8] == 8'd0) live = 1'b0;
         if (live) begin
            k[b*8 +: 8] = raw[b*8 +: 8];
            h = (h ^ {56'd0, raw[b*8 +: 8]}) * 64'h100000001b3;
         end
      end
      h = h * 64'h100000001b3;
      return h[7:0];
   endfunction

   // walks the predicted table exactly like the block should
   function automatic rsp_type table_predict(input req_type r);
      rsp_type     o;
      logic [63:0] k;
      logic [7:0]  idx;
      logic [8:0]  stp;
      logic        used, same;
      o = '0;
      o.status = ST_NOT_FOUND;
      idx = home_slot(r.key_bytes, k);
      stp = (r.command == CMD_INSERT) ? 9'd1 : 9'd0;
      if (r.command != CMD_UNDEF) begin
         if (r.command == CMD_INSERT && r.value == 32'd0) begin
            o.status = ST_NULL;
         end else begin
            o.status = ST_FULL;
            for (int n = 0; n < cur_limit; n++) begin
               used = tbl_used[idx];
               same = used && tbl_key[idx] == k;
               if (r.command == CMD_INSERT) begin
                  if (!used) begin
                     tbl_used[idx] = 1'b1;
                     tbl_key[idx]  = k;
                     tbl_val[idx]  = r.value;
                     tbl_count++;
                     o.status = ST_INSERTED;
                     o.slot_index = idx;
                     break;
                  end
                  if (same) begin
                     tbl_val[idx] = r.value;
                     o.status = ST_UPDATED;
                     o.slot_index = idx;
                     break;
                  end
               end else begin
                  if (!used) begin
                     o.status = ST_NOT_FOUND;
                     break;
                  end
                  if (same) begin
                     o.slot_index = idx;
                     if (r.command == CMD_LOOKUP) begin
                        o.status = ST_FOUND;
                        o.value_out = tbl_val[idx];
                     end else begin
                        tbl_used[idx] = 1'b0;
                        if (tbl_count > 0) tbl_count--;
                        o.status = ST_REMOVED;
                     end
                     break;
                  end
               end
               idx = idx + 8'(stp * stp);
               stp++;
            end
         end
      end
      o.entry_count = tbl_count;
      case (o.status)
         ST_INSERTED:  n_ins++;
         ST_UPDATED:   n_upd++;
         ST_FOUND:     n_found++;
         ST_NOT_FOUND: n_miss++;
         ST_REMOVED:   n_rem++;
         ST_FULL:      n_full++;
         default:      n_null++;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // response checker, receiver stalls on its own pattern
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_data.status), 32'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.value_out !== want.value_out)
                  report_mismatch("value_out", rsp_data.value_out, want.value_out);
               if (rsp_data.slot_index !== want.slot_index)
                  report_mismatch("slot_index", 32'(rsp_data.slot_index),
                                  32'(want.slot_index));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_data.entry_count),
                                  32'(want.entry_count));
            end
         end
         // stall pattern: long ready stretches, then mostly-stalled stretches
         if ((rsp_seen / 64) % 3 == 2) rsp_ready <= ($urandom_range(0, 3) == 0);
         else rsp_ready <= ($urandom_range(0, 7) != 0);
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired, %0d responses outstanding", pending_rsp.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // send one command; bursts with random gaps between them
   task automatic send_command(input logic [1:0] cmd, input logic [63:0] key,
                               input logic [31:0] val);
      req_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
      if (gap_left > 0) req_valid <= 1'b0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      burst_left--;
      r.command   = cmd;
      r.key_bytes = key;
      r.value     = val;
      req_valid  <= 1'b1;
      req_data   <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_predict(r));
      // valid stays high into the next transaction unless a gap or a wait follows
   endtask

   // wait for every response, then a little slack for the pipeline to settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_limit = lim;
   endtask

   // short keys clash often; key bytes past a zero must be ignored
   function automatic logic [63:0] random_key;
      logic [63:0] k;
      logic [63:0] m;
      int          len;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         k   = key_pool[$urandom_range(0, 15)];
         len = $urandom_range(0, 3);
         m   = {64{1'b1}} << (8*len+8);
         if ($urandom_range(0, 2) == 0) k = (k & ~m) | ({$urandom, $urandom} & m);
      end
      return k;
   endfunction

   function automatic logic [31:0] random_value;
      return ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
   endfunction

   task automatic test_directed;
      send_command(CMD_LOOKUP, 64'd0, 32'd0);                      // empty key miss
      send_command(CMD_INSERT, 64'd0, 32'hffff_ffff);              // empty key insert
      send_command(CMD_LOOKUP, 64'hffff_ffff_ffff_ff00, 32'd0);    // also the empty key
      send_command(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'd1);    // full length key
      send_command(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h8000_0000);
      send_command(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'd0);
      send_command(CMD_INSERT, 64'h41, 32'd0);                     // null value
      send_command(CMD_UNDEF, 64'h41, 32'h1234);                   // undefined command
      send_command(CMD_INSERT, 64'h41, 32'h5555_aaaa);
      send_command(CMD_INSERT, 64'h4241, 32'haaaa_5555);
      send_command(CMD_REMOVE, 64'h41, 32'd0);
      send_command(CMD_REMOVE, 64'h41, 32'd0);
      send_command(CMD_LOOKUP, 64'h4241, 32'd0);
      send_command(CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 32'd0);
      send_command(CMD_REMOVE, 64'd0, 32'd0);
      send_command(CMD_REMOVE, 64'h4241, 32'd0);
   endtask

   // one probe per command: colliding inserts report full, then limit 0
   task automatic test_probe_limits;
      write_limit(9'd1);
      for (int i = 0; i < 12; i++) send_command(CMD_INSERT, key_pool[i], $urandom | 1);
      for (int i = 0; i < 12; i++) send_command(CMD_LOOKUP, key_pool[i], 32'd0);
      write_limit(9'd0);
      send_command(CMD_INSERT, 64'h77, 32'd9);
      send_command(CMD_LOOKUP, key_pool[0], 32'd0);
      write_limit(9'd3);
      for (int i = 0; i < 12; i++) send_command(CMD_REMOVE, key_pool[i], 32'd0);
   endtask

   // fill the table well past half with the limit at its top
   task automatic test_fill;
      write_limit(9'd256);
      for (int i = 0; i < 300; i++) send_command(CMD_INSERT, {$urandom, $urandom}, $urandom);
      for (int i = 0; i < 100; i++)
         send_command(2'($urandom_range(0, 2)), random_key(), random_value());
   endtask

   // mixed traffic over a small pool of keys at several limits
   task automatic test_random_mix(input int count, input logic [LIMIT_W-1:0] lim);
      logic [1:0] cmd;
      write_limit(lim);
      // empty the table from the predicted state to keep probe chains short
      for (int s = 0; s < TABLE_SIZE; s++)
         if (tbl_used[s] && cur_limit != 0) send_command(CMD_REMOVE, tbl_key[s], 32'd0);
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(0, 40) == 0) ? CMD_UNDEF : 2'($urandom_range(0, 2));
         send_command(cmd, random_key(), random_value());
         if (i == count / 2) drain();   // sender holds off until all responses arrive
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      fail_count = 0;
      rsp_seen   = 0;
      burst_left = 0;
      gap_left   = 0;
      {n_ins, n_upd, n_found, n_miss, n_rem, n_full, n_null} = '0;
      tbl_count  = '0;
      cur_limit  = LIMIT_RESET;
      for (int s = 0; s < TABLE_SIZE; s++) tbl_used[s] = 1'b0;
      for (int i = 0; i < 16; i++)
         key_pool[i] = {$urandom_range(0, 255), $urandom_range(1, 255)};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_probe_limits();
      test_fill();
      test_random_mix(300, 9'd256);
      test_random_mix(250, 9'd5);
      test_random_mix(300, 9'd2);
      test_random_mix(150, 9'd1);
      drain();

      $display("covered %0d inserts, %0d updates, %0d found, %0d misses, %0d removes",
               n_ins, n_upd, n_found, n_miss, n_rem);
      $display("plus %0d table-full and %0d null-value responses, probe limits 0 to 256",
               n_full, n_null);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/htqp_pkg.sv
rtl/htqp_front.sv
rtl/htqp_fifo.sv
rtl/htqp_back.sv
rtl/hash_table_quadratic_probe.sv
tb/hash_table_quadratic_probe_test.sv
